FILE: rtl/bba_pkg.sv
// bba_pkg: shared constants, codes and types of the bitmap block allocator
`default_nettype none
package bba_pkg;

    // pool geometry
    localparam int MAX_BLOCKS = 256;
    localparam int BYTE_W     = 8;
    localparam int MAP_BYTES  = (MAX_BLOCKS + BYTE_W - 1) / BYTE_W;
    localparam int ADDR_W     = $clog2(MAP_BYTES);
    localparam int BIT_W      = $clog2(BYTE_W);
    localparam int IDX_W      = ADDR_W + BIT_W;

    // field widths
    localparam int OFFSET_W = 20;
    localparam int SIZE_W   = 13;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;

    // opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_CHK,
        S_MUL,
        S_DIV,
        S_FREE_CHK,
        S_DONE
    } bba_state_t;

    // bitmap memory access request
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } map_req_t;

endpackage
`default_nettype wire

FILE: rtl/bba_map_ram.sv
// bba_map_ram: bitmap byte memory with per-byte valid bits cleared at reset
`default_nettype none
module bba_map_ram
    import bba_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire map_req_t          req,
    output logic      [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0]    mem [MAP_BYTES];
    logic [MAP_BYTES-1:0] vld_reg;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;

    // storage write and registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // valid bits: a byte never written reads as all free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

FILE: rtl/bba_divider.sv
// bba_divider: restoring divider, one quotient bit per cycle
`default_nettype none
module bba_divider
    import bba_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [OFFSET_W-1:0] dividend,
    input  wire logic [SIZE_W-1:0]   divisor,
    output logic                     done,
    output logic      [OFFSET_W-1:0] quotient
);

    localparam int CNT_W = $clog2(OFFSET_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [OFFSET_W-1:0] quot_reg, quot_next;
    logic [SIZE_W-1:0]   dsr_reg, dsr_next;
    logic [SIZE_W:0]     trial;

    // one shift-compare-subtract step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quot_reg[OFFSET_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OFFSET_W);
            rem_next  = '0;
            quot_next = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next  = SIZE_W'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[OFFSET_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[SIZE_W-1:0];
                quot_next = {quot_reg[OFFSET_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

FILE: rtl/bitmap_block_allocator_core.sv
// bitmap_block_allocator_core: first-fit block allocator over a used-mark bitmap
//
// Input beats (s_valid/s_ready) carry an opcode and, for a free, an element
// offset. Every input beat yields exactly one result beat (m_valid/m_ready)
// with a status, the block index and, for an allocate, the element offset.
// Items are handled one at a time; s_ready is high only while the sequencer
// is idle. An allocate reads one bitmap byte per cycle from the map memory,
// scanning up to 32 bytes in order until it finds a clear mark below the
// limit. A free runs the restoring divider, one quotient bit per cycle, then
// reads one byte and, if the block is marked, writes it back. The bitmap read
// port sets the scan rate.
// A result waits in the output register while the receiver stalls; the
// sequencer holds the following result until that register is free.
// Reset (aresetn low, synchronous) marks every block free at once through
// per-byte valid bits and restores block_size 1 and block_count 256.
// Configuration writes (cfg_we) belong only in idle; the user must keep to this, as the block does not enforce it.
`default_nettype none
module bitmap_block_allocator_core
    import bba_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_opcode,
    input  wire logic [OFFSET_W-1:0]   s_block_offset,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [STATUS_W-1:0]   m_status,
    output logic      [IDX_W-1:0]      m_block_index,
    output logic      [OFFSET_W-1:0]   m_result_offset
);

    bba_state_t state_reg, state_next;

    logic [SIZE_W-1:0]   block_size_reg;
    logic [COUNT_W-1:0]  block_count_reg;
    logic [COUNT_W-1:0]  limit;

    logic [ADDR_W-1:0]   byte_reg, byte_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_index_reg, res_index_next;
    logic [OFFSET_W-1:0] res_offset_reg, res_offset_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [IDX_W-1:0]    m_index_reg, m_index_next;
    logic [OFFSET_W-1:0] m_offset_reg, m_offset_next;

    map_req_t            map_req;
    logic [BYTE_W-1:0]   map_rd_data;

    logic                div_start;
    logic                div_done;
    logic [OFFSET_W-1:0] div_quot;

    logic                scan_found;
    logic [BIT_W-1:0]    scan_bit;
    logic [ADDR_W:0]     byte_inc;
    logic [IDX_W+SIZE_W-1:0] prod;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg  <= SIZE_W'(1);
            block_count_reg <= COUNT_W'(MAX_BLOCKS);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BLOCK_SIZE:  block_size_reg  <= cfg_data[SIZE_W-1:0];
                REG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // usable block count, saturated to the pool size
    assign limit = (block_count_reg > COUNT_W'(MAX_BLOCKS)) ?
                   COUNT_W'(MAX_BLOCKS) : block_count_reg;

    // lowest clear mark in the byte just read that lies below the limit
    always_comb begin
        logic [IDX_W-1:0] bidx;
        scan_found = 1'b0;
        scan_bit   = '0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            bidx = {byte_reg, BIT_W'(b)};
            if (!map_rd_data[b] && ({1'b0, bidx} < limit)) begin
                scan_found = 1'b1;
                scan_bit   = BIT_W'(b);
            end
        end
    end

    assign byte_inc = {1'b0, byte_reg} + (ADDR_W+1)'(1);
    assign prod     = {{SIZE_W{1'b0}}, idx_reg} * {{IDX_W{1'b0}}, block_size_reg};

    // sequencer: next state, memory requests and result fields
    always_comb begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_offset_next = res_offset_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_offset_next   = m_offset_reg;
        map_req         = '0;
        div_start       = 1'b0;
        s_ready         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == OP_ALLOC) begin
                        if (limit == '0) begin
                            res_status_next = ST_FULL;
                            res_index_next  = '0;
                            res_offset_next = '0;
                            state_next      = S_DONE;
                        end else begin
                            map_req.rd_en   = 1'b1;
                            map_req.rd_addr = '0;
                            byte_next       = '0;
                            state_next      = S_ALLOC_CHK;
                        end
                    end else begin
                        if (block_size_reg == '0) begin
                            res_status_next = ST_RANGE;
                            res_index_next  = '0;
                            res_offset_next = '0;
                            state_next      = S_DONE;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                end
            end

            S_ALLOC_CHK: begin
                if (scan_found) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = byte_reg;
                    map_req.wr_data = map_rd_data | (BYTE_W'(1) << scan_bit);
                    idx_next        = {byte_reg, scan_bit};
                    state_next      = S_MUL;
                end else if ({byte_inc, {BIT_W{1'b0}}} >= limit) begin
                    res_status_next = ST_FULL;
                    res_index_next  = '0;
                    res_offset_next = '0;
                    state_next      = S_DONE;
                end else begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = byte_inc[ADDR_W-1:0];
                    byte_next       = byte_inc[ADDR_W-1:0];
                end
            end

            S_MUL: begin
                res_status_next = ST_OK;
                res_index_next  = idx_reg;
                res_offset_next = prod[OFFSET_W-1:0];
                state_next      = S_DONE;
            end

            S_DIV: begin
                if (div_done) begin
                    if (div_quot >= {{(OFFSET_W-COUNT_W){1'b0}}, limit}) begin
                        res_status_next = ST_RANGE;
                        res_index_next  = '0;
                        res_offset_next = '0;
                        state_next      = S_DONE;
                    end else begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = div_quot[IDX_W-1:BIT_W];
                        idx_next        = div_quot[IDX_W-1:0];
                        state_next      = S_FREE_CHK;
                    end
                end
            end

            S_FREE_CHK: begin
                res_index_next  = idx_reg;
                res_offset_next = '0;
                if (!map_rd_data[idx_reg[BIT_W-1:0]]) begin
                    res_status_next = ST_NOT_USED;
                end else begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = idx_reg[IDX_W-1:BIT_W];
                    map_req.wr_data = map_rd_data &
                                      ~(BYTE_W'(1) << idx_reg[BIT_W-1:0]);
                    res_status_next = ST_OK;
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_offset_next = res_offset_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_offset_reg <= res_offset_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_offset_reg   <= m_offset_next;
    end

    // bitmap memory
    bba_map_ram u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (map_req),
        .rd_data (map_rd_data)
    );

    // offset to block index
    bba_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_block_offset),
        .divisor  (block_size_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_block_index   = m_index_reg;
    assign m_result_offset = m_offset_reg;

endmodule
`default_nettype wire

FILE: tb/tb_bitmap_block_allocator_core.sv
// testbench for the bitmap block allocator: directed and random alloc/free traffic
module tb_bitmap_block_allocator_core
    import bba_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [OFFSET_W-1:0] offset;
    } pool_answer_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BLOCK_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_opcode = OP_ALLOC;
    logic [OFFSET_W-1:0]   s_block_offset = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [IDX_W-1:0]      m_block_index;
    logic [OFFSET_W-1:0]   m_result_offset;

    // shadow copy of the allocator state
    logic [MAX_BLOCKS-1:0] used_marks = '0;
    logic [SIZE_W-1:0]     pool_block_size = 13'd1;
    logic [COUNT_W-1:0]    pool_block_count = 9'd256;

    pool_answer_t pool_answers[$];
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    bitmap_block_allocator_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_block_offset  (s_block_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_block_index   (m_block_index),
        .m_result_offset (m_result_offset)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // number of blocks that may be handed out, saturated to the pool size
    function automatic int usable_blocks();
        return (int'(pool_block_count) > MAX_BLOCKS) ? MAX_BLOCKS
                                                     : int'(pool_block_count);
    endfunction

    // first-fit allocate or free, updating the shadow bitmap
    function automatic pool_answer_t pool_answer(input logic op,
                                                 input logic [OFFSET_W-1:0] offset);
        pool_answer_t answer;
        int limit;
        int idx;
        int quotient;
        int product;
        bit found;
        answer = '0;
        limit = usable_blocks();
        found = 1'b0;
        if (op == OP_ALLOC) begin
            answer.status = ST_FULL;
            for (idx = 0; idx < limit && !found; idx++) begin
                if (!used_marks[idx]) begin
                    found = 1'b1;
                    used_marks[idx] = 1'b1;
                    product = idx * int'(pool_block_size);
                    answer.status = ST_OK;
                    answer.index = idx[IDX_W-1:0];
                    answer.offset = product[OFFSET_W-1:0];
                end
            end
        end else if (pool_block_size == '0) begin
            answer.status = ST_RANGE;
        end else begin
            quotient = int'(offset) / int'(pool_block_size);
            if (quotient >= limit) begin
                answer.status = ST_RANGE;
            end else begin
                answer.index = quotient[IDX_W-1:0];
                if (!used_marks[quotient]) begin
                    answer.status = ST_NOT_USED;
                end else begin
                    used_marks[quotient] = 1'b0;
                    answer.status = ST_OK;
                end
            end
        end
        return answer;
    endfunction

    // register write, only while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_BLOCK_SIZE) begin
            pool_block_size = data;
        end else begin
            pool_block_count = data[COUNT_W-1:0];
        end
    endtask

    // one request beat, with an optional gap before it
    task automatic send_request(input logic op, input logic [OFFSET_W-1:0] offset);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_block_offset <= offset;
        do @(posedge aclk); while (!s_ready);
        pool_answers.push_back(pool_answer(op, offset));
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pool_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // defaults after reset: size 1, count 256
    task automatic test_reset_state();
        send_request(OP_ALLOC, 20'hFFFFF);
        send_request(OP_ALLOC, 20'h00000);
        send_request(OP_ALLOC, 20'h5A5A5);
        send_request(OP_FREE, 20'd1);
        send_request(OP_FREE, 20'd1);
        send_request(OP_ALLOC, 20'hA5A5A);
        send_request(OP_FREE, 20'hFFFFF);
        send_request(OP_FREE, 20'd255);
        send_request(OP_FREE, 20'd0);
    endtask

    // largest block size, tiny pool: full pool, offset inside a block, out of range
    task automatic test_block_geometry();
        wait_idle();
        write_register(REG_BLOCK_SIZE, 13'h1FFF);
        write_register(REG_BLOCK_COUNT, 13'd3);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_FREE, 20'd8191 + 20'd5);
        send_request(OP_FREE, 20'd3 * 20'd8191);
    endtask

    // zero block size, zero block count, count above the pool size
    task automatic test_degenerate_config();
        wait_idle();
        write_register(REG_BLOCK_SIZE, 13'd0);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_FREE, 20'd0);
        wait_idle();
        write_register(REG_BLOCK_COUNT, 13'd0);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_FREE, 20'd0);
        wait_idle();
        write_register(REG_BLOCK_SIZE, 13'd4096);
        write_register(REG_BLOCK_COUNT, 13'd511);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_FREE, 20'hFFFFF);
    endtask

    // random segments, each under a fresh configuration
    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int items);
        int seg;
        int n;
        int alloc_pct;
        int limit;
        int idx;
        int tries;
        int pick;
        logic [CFG_DATA_W-1:0] size_data;
        logic [CFG_DATA_W-1:0] count_data;
        logic [OFFSET_W-1:0] offset;
        wait_idle();
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (seg = 0; seg < 5; seg++) begin
            wait_idle();
            case ($urandom_range(0, 6))
                0: size_data = 13'd1;
                1: size_data = CFG_DATA_W'($urandom_range(2, 16));
                2: size_data = 13'd4096;
                3: size_data = 13'h1FFF;
                4: size_data = CFG_DATA_W'($urandom);
                5: size_data = CFG_DATA_W'($urandom_range(17, 300));
                default: size_data = (seg == 2) ? 13'd0
                                                : CFG_DATA_W'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 7))
                0: count_data = 13'd256;
                1: count_data = 13'd1;
                2: count_data = 13'd8;
                3: count_data = CFG_DATA_W'($urandom_range(9, 32));
                4: count_data = CFG_DATA_W'($urandom);
                5: count_data = CFG_DATA_W'($urandom_range(100, 256));
                6: count_data = (seg == 3) ? 13'd0 : 13'd2;
                default: count_data = CFG_DATA_W'($urandom_range(2, 40));
            endcase
            write_register(REG_BLOCK_SIZE, size_data);
            write_register(REG_BLOCK_COUNT, count_data);
            alloc_pct = $urandom_range(30, 70);
            for (n = 0; n < items / 5; n++) begin
                limit = usable_blocks();
                offset = OFFSET_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < alloc_pct) begin
                    send_request(OP_ALLOC, offset);
                end else begin
                    // mostly aim at a block that is in use
                    if (pick < alloc_pct + (100 - alloc_pct) * 3 / 4 && limit > 0
                            && pool_block_size != '0) begin
                        idx = $urandom_range(0, limit - 1);
                        for (tries = 0; tries < limit && !used_marks[idx]; tries++) begin
                            idx = (idx + 1) % limit;
                        end
                        tries = idx * int'(pool_block_size)
                              + $urandom_range(0, int'(pool_block_size) - 1);
                        if (tries <= 'hFFFFF) begin
                            offset = tries[OFFSET_W-1:0];
                        end
                    end else if ($urandom_range(0, 1) == 1) begin
                        tries = limit * int'(pool_block_size) + 2;
                        if (tries > 'hFFFFF) tries = 'hFFFFF;
                        offset = OFFSET_W'($urandom_range(0, tries));
                    end
                    send_request(OP_FREE, offset);
                end
            end
        end
    endtask

    // result checking against the oldest prediction; receiver stalls
    always @(posedge aclk) begin
        pool_answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pool_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result beat: status %0d index %0d offset %0d",
                             m_status, m_block_index, m_result_offset);
                end
            end else begin
                want = pool_answers.pop_front();
                if (m_status != want.status || m_block_index != want.index
                        || m_result_offset != want.offset) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"mismatch: status %0d/%0d index %0d/%0d ",
                                  "offset %0d/%0d (exp/act)"},
                                 want.status, m_status, want.index, m_block_index,
                                 want.offset, m_result_offset);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_block_geometry();
        test_degenerate_config();
        test_random_traffic(0, 0, 310);
        test_random_traffic(83, 0, 310);
        test_random_traffic(0, 83, 310);
        test_random_traffic(34, 34, 310);
        wait_idle();
        mismatch_count += pool_answers.size();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
